FILE: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define DPP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Condition that must hold at every rising clock edge outside reset.
`define DPP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/dpp_pkg.sv
// Types and constants shared by the depth-to-point block.
`timescale 1ns / 1ps
package dpp_pkg;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QW     = 2;
  localparam int unsigned QBITS  = 18;

  typedef enum logic [2:0] {
    CFG_X_OFFSET  = 3'd0,
    CFG_CENTER_X  = 3'd1,
    CFG_CENTER_Y  = 3'd2,
    CFG_FOCAL_X   = 3'd3,
    CFG_FOCAL_Y   = 3'd4,
    CFG_FAR_DEPTH = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_CONVERT = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [6:0] x_offset;
    logic [13:0]       center_x;
    logic [13:0]       center_y;
    logic [13:0]       focal_x;
    logic [13:0]       focal_y;
    logic [15:0]       far_depth;
  } cfg_t;

  // One convert item on its way from the front to the back.
  typedef struct packed {
    logic [15:0]        z;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
  } item_t;
endpackage

FILE: rtl/core/depth_pixel_to_point.sv
// Top level: depth pixels to 3D points through a distance table.
//  channel | handshake                  | beat
//  input   | push_i / full_o            | opcode, depth_code, pixel_x, pixel_y, table_value
//  result  | pop_i / empty_o            | point_x, point_y, point_z
//  config  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
// One item is accepted per cycle while full_o is low; a convert beat passes the front register,
// the queue and the back-end pipeline, whose divider makes one quotient bit per stage.
// Reset clears control state only; the distance table is undefined until loaded.
// A stalled result halts the back end; the queue then fills and full_o rises.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module depth_pixel_to_point #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic               opcode_i,
  input  logic [10:0]        depth_code_i,
  input  logic [9:0]         pixel_x_i,
  input  logic [9:0]         pixel_y_i,
  input  logic [15:0]        table_value_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic signed [17:0] point_x_o,
  output logic signed [17:0] point_y_o,
  output logic [15:0]        point_z_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  dpp_pkg::cfg_t        cfg_q;
  logic                 acc;
  logic                 f_valid;
  dpp_pkg::item_t       f_item, q_item;
  logic                 q_nempty, take;
  logic [dpp_pkg::QW:0] q_cnt;
  logic [dpp_pkg::QW+1:0] used;
  logic [17:0]          px, py;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_offset  <= -7'sd8;
      cfg_q.center_x  <= 14'd5120;
      cfg_q.center_y  <= 14'd3840;
      cfg_q.focal_x   <= 14'd9504;
      cfg_q.focal_y   <= 14'd9504;
      cfg_q.far_depth <= 16'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dpp_pkg::CFG_X_OFFSET:  cfg_q.x_offset  <= cfg_data_i[6:0];
        dpp_pkg::CFG_CENTER_X:  cfg_q.center_x  <= cfg_data_i[13:0];
        dpp_pkg::CFG_CENTER_Y:  cfg_q.center_y  <= cfg_data_i[13:0];
        dpp_pkg::CFG_FOCAL_X:   cfg_q.focal_x   <= cfg_data_i[13:0];
        dpp_pkg::CFG_FOCAL_Y:   cfg_q.focal_y   <= cfg_data_i[13:0];
        dpp_pkg::CFG_FAR_DEPTH: cfg_q.far_depth <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front stage holds one beat on its way into the queue, so count it too.
  assign used   = (dpp_pkg::QW+2)'(q_cnt) + (dpp_pkg::QW+2)'(f_valid);
  assign full_o = used >= (dpp_pkg::QW+2)'(dpp_pkg::QDEPTH);
  assign acc    = push_i && !full_o;

  dpp_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
    .clk_i (clk_i), .rst_ni (rst_ni), .cfg_i (cfg_q), .acc_i (acc),
    .opcode_i (opcode_i), .depth_code_i (depth_code_i), .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i), .table_value_i (table_value_i),
    .valid_o (f_valid), .item_o (f_item)
  );

  dpp_fifo u_fifo (
    .clk_i (clk_i), .rst_ni (rst_ni), .wr_i (f_valid), .wdata_i (f_item),
    .rd_i (take), .rdata_o (q_item), .nempty_o (q_nempty), .count_o (q_cnt)
  );

  dpp_back u_back (
    .clk_i (clk_i), .rst_ni (rst_ni), .cfg_i (cfg_q), .in_valid_i (q_nempty),
    .item_i (q_item), .take_o (take), .pop_i (pop_i), .empty_o (empty_o),
    .point_x_o (px), .point_y_o (py), .point_z_o (point_z_o)
  );

  assign point_x_o = $signed(px);
  assign point_y_o = $signed(py);

  `DPP_ASSERT_ALWAYS(a_queue_bound, clk_i, rst_ni, used <= (dpp_pkg::QW+2)'(dpp_pkg::QDEPTH))
  `DPP_ASSERT_IMPLY(a_no_take_empty, clk_i, rst_ni, take, q_nempty)
  `DPP_ASSERT_IMPLY(a_load_no_front, clk_i, rst_ni, acc && !opcode_i, ##1 !f_valid)
endmodule

FILE: rtl/core/dpp_front.sv
// Front end: distance table, item classification and centering.
`timescale 1ns / 1ps
module dpp_front #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dpp_pkg::cfg_t  cfg_i,
  input  logic           acc_i,
  input  logic           opcode_i,
  input  logic [10:0]    depth_code_i,
  input  logic [9:0]     pixel_x_i,
  input  logic [9:0]     pixel_y_i,
  input  logic [15:0]    table_value_i,
  output logic           valid_o,
  output dpp_pkg::item_t item_o
);
  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam logic [11:0] LIMIT = 12'(TABLE_ENTRIES);

  logic [15:0]        mem_q [TABLE_ENTRIES];
  logic [15:0]        rd_q;
  logic               valid_q;
  logic               far_q;
  logic signed [17:0] nx_q, ny_q;
  logic               in_range;
  logic               is_conv;
  logic signed [17:0] nx_d, ny_d;

  assign in_range = {1'b0, depth_code_i} < LIMIT;
  assign is_conv  = (opcode_i == dpp_pkg::OP_CONVERT);

  always_comb begin
    nx_d = (($signed({8'b0, pixel_x_i}) + {{11{cfg_i.x_offset[6]}}, cfg_i.x_offset}) <<< 4)
           - $signed({4'b0, cfg_i.center_x});
    ny_d = $signed({4'b0, pixel_y_i, 4'b0}) - $signed({4'b0, cfg_i.center_y});
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && !is_conv && in_range) begin
      mem_q[depth_code_i[AW-1:0]] <= table_value_i;
    end
    if (acc_i && is_conv) begin
      rd_q <= mem_q[depth_code_i[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= acc_i && is_conv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && is_conv) begin
      far_q <= !in_range;
      nx_q  <= nx_d;
      ny_q  <= ny_d;
    end
  end

  assign valid_o   = valid_q;
  assign item_o.z  = far_q ? cfg_i.far_depth : rd_q;
  assign item_o.nx = nx_q;
  assign item_o.ny = ny_q;
endmodule

FILE: rtl/core/dpp_fifo.sv
// Short queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module dpp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  dpp_pkg::item_t wdata_i,
  input  logic           rd_i,
  output dpp_pkg::item_t rdata_o,
  output logic           nempty_o,
  output logic [dpp_pkg::QW:0] count_o
);
  dpp_pkg::item_t          buf_q [dpp_pkg::QDEPTH];
  logic [dpp_pkg::QW-1:0]  wp_q, rp_q;
  logic [dpp_pkg::QW:0]    cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      buf_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign rdata_o  = buf_q[rp_q];
  assign nempty_o = cnt_q != '0;
  assign count_o  = cnt_q;
endmodule

FILE: rtl/core/dpp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
module dpp_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [32:0] num_i,
  input  logic [14:0] den2_i,
  output logic [dpp_pkg::QBITS-1:0] quo_o,
  output logic        ovf_o
);
  localparam int unsigned NB = dpp_pkg::QBITS;

  logic [32:0]   r_q [NB+1];
  logic [14:0]   d_q [NB+1];
  logic [NB-1:0] q_q [NB+1];
  logic          o_q [NB+1];

  // Overflow means the quotient does not fit in the quotient bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= num_i;
      d_q[0] <= den2_i;
      q_q[0] <= '0;
      o_q[0] <= num_i >= {den2_i, 18'b0};
    end
  end

  for (genvar k = 1; k <= NB; k++) begin : g_stage
    logic [32:0] t;
    logic        ge;
    assign t  = 33'(d_q[k-1]) << (NB - k);
    assign ge = r_q[k-1] >= t;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= ge ? (r_q[k-1] - t) : r_q[k-1];
        d_q[k] <= d_q[k-1];
        o_q[k] <= o_q[k-1];
        q_q[k] <= q_q[k-1] | (NB'(ge) << (NB - k));
      end
    end
  end

  assign quo_o = q_q[NB];
  assign ovf_o = o_q[NB];
endmodule

FILE: rtl/core/dpp_back.sv
// Back end: multiply by depth, divide by focal length, round and saturate.
`timescale 1ns / 1ps
module dpp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dpp_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  input  dpp_pkg::item_t item_i,
  output logic           take_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [17:0]    point_x_o,
  output logic [17:0]    point_y_o,
  output logic [15:0]    point_z_o
);
  localparam int unsigned DL = dpp_pkg::QBITS + 1;
  localparam logic [17:0] POS_MAX = 18'd131071;
  localparam logic [17:0] NEG_MAX = 18'd131072;

  logic        adv;
  logic        a_v_q, b_v_q;
  logic [16:0] a_ax_q, a_ay_q;
  logic        a_nx_q, a_ny_q, b_nx_q, b_ny_q;
  logic [15:0] a_z_q, b_z_q;
  logic [32:0] b_mx_q, b_my_q;
  logic        sv_q [DL];
  logic        sx_q [DL];
  logic        sy_q [DL];
  logic [15:0] sz_q [DL];
  logic [13:0] denx, deny;
  logic [32:0] numx, numy;
  logic [17:0] qx, qy;
  logic        ox, oy;
  logic        out_v_q;
  logic [17:0] px_q, py_q;
  logic [15:0] pz_q;
  logic [17:0] rx, ry;

  // The whole back end moves only while the output register can take a beat.
  assign adv    = !out_v_q || pop_i;
  assign take_o = adv && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      for (int i = 0; i < DL; i++) sv_q[i] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      sv_q[0] <= b_v_q;
      for (int i = 1; i < DL; i++) sv_q[i] <= sv_q[i-1];
      out_v_q <= sv_q[DL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_nx_q <= item_i.nx[17];
      a_ny_q <= item_i.ny[17];
      a_ax_q <= item_i.nx[17] ? 17'(-item_i.nx) : item_i.nx[16:0];
      a_ay_q <= item_i.ny[17] ? 17'(-item_i.ny) : item_i.ny[16:0];
      a_z_q  <= item_i.z;
      b_mx_q <= 33'(a_ax_q) * 33'(a_z_q);
      b_my_q <= 33'(a_ay_q) * 33'(a_z_q);
      b_nx_q <= a_nx_q;
      b_ny_q <= a_ny_q;
      b_z_q  <= a_z_q;
      sx_q[0] <= b_nx_q;
      sy_q[0] <= b_ny_q;
      sz_q[0] <= b_z_q;
      for (int i = 1; i < DL; i++) begin
        sx_q[i] <= sx_q[i-1];
        sy_q[i] <= sy_q[i-1];
        sz_q[i] <= sz_q[i-1];
      end
    end
  end

  // A zero focal length acts as one; rounding adds half the divisor.
  assign denx = (cfg_i.focal_x == '0) ? 14'd1 : cfg_i.focal_x;
  assign deny = (cfg_i.focal_y == '0) ? 14'd1 : cfg_i.focal_y;
  assign numx = 33'({b_mx_q[31:0], 1'b0}) + 33'(denx);
  assign numy = 33'({b_my_q[31:0], 1'b0}) + 33'(deny);

  dpp_div u_div_x (
    .clk_i (clk_i), .en_i (adv), .num_i (numx), .den2_i ({denx, 1'b0}),
    .quo_o (qx), .ovf_o (ox)
  );
  dpp_div u_div_y (
    .clk_i (clk_i), .en_i (adv), .num_i (numy), .den2_i ({deny, 1'b0}),
    .quo_o (qy), .ovf_o (oy)
  );

  always_comb begin
    if (sx_q[DL-1]) rx = (ox || qx > NEG_MAX) ? NEG_MAX : 18'(-qx);
    else            rx = (ox || qx > POS_MAX) ? POS_MAX : qx;
    if (sy_q[DL-1]) ry = (oy || qy > NEG_MAX) ? NEG_MAX : 18'(-qy);
    else            ry = (oy || qy > POS_MAX) ? POS_MAX : qy;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= rx;
      py_q <= ry;
      pz_q <= sz_q[DL-1];
    end
  end

  assign empty_o   = !out_v_q;
  assign point_x_o = px_q;
  assign point_y_o = py_q;
  assign point_z_o = pz_q;
endmodule

FILE: tb/sv/depth_pixel_to_point_tb.sv
// Self-checking testbench for the depth pixel to 3D point converter.
`timescale 1ns / 1ps
module depth_pixel_to_point_tb;

  localparam int unsigned NUM_ENTRIES = 1024;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [2:0] CFG_UNUSED = 3'd6;
  localparam logic [2:0] CFG_UNUSED_TOP = 3'd7;

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic [15:0]        z;
  } point_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push_i = 1'b0;
  logic               full_o;
  logic               opcode_i = 1'b0;
  logic [10:0]        depth_code_i = '0;
  logic [9:0]         pixel_x_i = '0;
  logic [9:0]         pixel_y_i = '0;
  logic [15:0]        table_value_i = '0;
  logic               pop_i = 1'b0;
  logic               empty_o;
  logic signed [17:0] point_x_o;
  logic signed [17:0] point_y_o;
  logic [15:0]        point_z_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;

  // Predictor state.
  logic [15:0]   dist_table [NUM_ENTRIES];
  bit            entry_loaded [NUM_ENTRIES];
  int            loaded_list [$];
  dpp_pkg::cfg_t cam;

  point_t expected_points [$];
  int     error_count = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_cycles = 0;
  longint cycle_count = 0;

  depth_pixel_to_point DUT (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [17:0] back_project(longint num, logic [15:0] z,
                                                      logic [13:0] focal);
    longint den;
    longint mag;
    longint q;
    den = (focal == 0) ? 1 : longint'(focal);
    mag = (num < 0 ? -num : num) * longint'(z);
    q = (2 * mag + den) / (2 * den);
    if (num < 0) q = -q;
    if (q > 131071) q = 131071;
    if (q < -131072) q = -131072;
    return q[17:0];
  endfunction

  function automatic point_t pixel_to_point(logic [10:0] raw, logic [9:0] px, logic [9:0] py);
    point_t p;
    longint nx;
    longint ny;
    p.z = (raw < NUM_ENTRIES) ? dist_table[raw] : cam.far_depth;
    nx = (longint'(px) + longint'(cam.x_offset)) * 16 - longint'(cam.center_x);
    ny = longint'(py) * 16 - longint'(cam.center_y);
    p.x = back_project(nx, p.z, cam.focal_x);
    p.y = back_project(ny, p.z, cam.focal_y);
    return p;
  endfunction

  // Result side: check each beat, then decide whether to pop next cycle.
  always @(posedge clk_i) begin
    point_t exp_p;
    if (rst_ni && pop_i && !empty_o) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d z=%0d", $time,
                 point_x_o, point_y_o, point_z_o);
        error_count++;
      end else begin
        exp_p = expected_points.pop_front();
        if (point_x_o !== exp_p.x) begin
          $display("%0t: point_x expected %0d actual %0d", $time, exp_p.x, point_x_o);
          error_count++;
        end
        if (point_y_o !== exp_p.y) begin
          $display("%0t: point_y expected %0d actual %0d", $time, exp_p.y, point_y_o);
          error_count++;
        end
        if (point_z_o !== exp_p.z) begin
          $display("%0t: point_z expected %0d actual %0d", $time, exp_p.z, point_z_o);
          error_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop_i <= 1'b0;
    end else begin
      pop_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(dpp_pkg::op_e op, logic [10:0] raw, logic [9:0] px,
                           logic [9:0] py, logic [15:0] tv);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i <= 1'b1;
    opcode_i <= op;
    depth_code_i <= raw;
    pixel_x_i <= px;
    pixel_y_i <= py;
    table_value_i <= tv;
    do @(posedge clk_i); while (full_o);
    if (op == dpp_pkg::OP_LOAD) begin
      if (raw < NUM_ENTRIES) begin
        dist_table[raw] = tv;
        if (!entry_loaded[raw]) loaded_list.push_back(raw);
        entry_loaded[raw] = 1'b1;
      end
    end else begin
      expected_points.push_back(pixel_to_point(raw, px, py));
    end
  endtask

  task automatic end_stream();
    push_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Loads leave no result, so allow the pipeline latency after the queue drains.
  task automatic wait_idle();
    end_stream();
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      dpp_pkg::CFG_X_OFFSET:  cam.x_offset = data[6:0];
      dpp_pkg::CFG_CENTER_X:  cam.center_x = data[13:0];
      dpp_pkg::CFG_CENTER_Y:  cam.center_y = data[13:0];
      dpp_pkg::CFG_FOCAL_X:   cam.focal_x = data[13:0];
      dpp_pkg::CFG_FOCAL_Y:   cam.focal_y = data[13:0];
      dpp_pkg::CFG_FAR_DEPTH: cam.far_depth = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_camera(logic [6:0] xoff, logic [13:0] cx, logic [13:0] cy,
                              logic [13:0] fx, logic [13:0] fy, logic [15:0] far);
    wait_idle();
    write_reg(dpp_pkg::CFG_X_OFFSET, {9'd0, xoff});
    write_reg(dpp_pkg::CFG_CENTER_X, {2'd0, cx});
    write_reg(dpp_pkg::CFG_CENTER_Y, {2'd0, cy});
    write_reg(dpp_pkg::CFG_FOCAL_X, {2'd0, fx});
    write_reg(dpp_pkg::CFG_FOCAL_Y, {2'd0, fy});
    write_reg(dpp_pkg::CFG_FAR_DEPTH, far);
    @(posedge clk_i);
  endtask

  // Converts only read loaded entries or the far range.
  task automatic send_random_item();
    logic [10:0] raw;
    if ($urandom_range(99) < 25) begin
      send_item(dpp_pkg::OP_LOAD, 11'($urandom_range(2047)), 10'($urandom), 10'($urandom),
                16'($urandom));
    end else begin
      if ($urandom_range(99) < 80 && loaded_list.size() != 0)
        raw = 11'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
      else
        raw = 11'($urandom_range(2047, NUM_ENTRIES));
      send_item(dpp_pkg::OP_CONVERT, raw, 10'($urandom), 10'($urandom), 16'($urandom));
    end
  endtask

  task automatic run_random(int count);
    repeat (count) send_random_item();
  endtask

  task automatic test_directed();
    send_item(dpp_pkg::OP_LOAD, 11'd0, 10'd0, 10'd0, 16'd0);
    send_item(dpp_pkg::OP_LOAD, 11'd1023, 10'd1023, 10'd1023, 16'hFFFF);
    send_item(dpp_pkg::OP_LOAD, 11'd512, 10'd0, 10'd0, 16'h1000);
    // Out-of-range loads must not disturb anything.
    send_item(dpp_pkg::OP_LOAD, 11'd1024, 10'd0, 10'd0, 16'h1234);
    send_item(dpp_pkg::OP_LOAD, 11'd2047, 10'd0, 10'd0, 16'hFFFF);
    send_item(dpp_pkg::OP_CONVERT, 11'd0, 10'd0, 10'd0, 16'd0);
    send_item(dpp_pkg::OP_CONVERT, 11'd1023, 10'd0, 10'd0, 16'hFFFF);
    send_item(dpp_pkg::OP_CONVERT, 11'd1023, 10'd1023, 10'd1023, 16'd0);
    send_item(dpp_pkg::OP_CONVERT, 11'd1023, 10'd0, 10'd1023, 16'd0);
    send_item(dpp_pkg::OP_CONVERT, 11'd512, 10'd320, 10'd240, 16'd0);
    send_item(dpp_pkg::OP_CONVERT, 11'd512, 10'd328, 10'd240, 16'd0);
    send_item(dpp_pkg::OP_CONVERT, 11'd1024, 10'd100, 10'd100, 16'd0);
    send_item(dpp_pkg::OP_CONVERT, 11'd2047, 10'd1023, 10'd0, 16'd0);
    wait_idle();
    write_reg(dpp_pkg::CFG_FAR_DEPTH, 16'hFFFF);
    write_reg(CFG_UNUSED, 16'hFFFF);
    write_reg(CFG_UNUSED_TOP, 16'h0000);
    send_item(dpp_pkg::OP_CONVERT, 11'd1024, 10'd0, 10'd0, 16'd0);
    send_item(dpp_pkg::OP_CONVERT, 11'd2047, 10'd1023, 10'd1023, 16'd0);
    send_item(dpp_pkg::OP_CONVERT, 11'd1500, 10'd512, 10'd384, 16'd0);
  endtask

  task automatic test_extreme_cameras();
    // A focal length of one on x (with far z at its maximum), then on y, drives that output into saturation.
    write_camera(7'h40, 14'd0, 14'd16383, 14'd1, 14'd16383, 16'hFFFF);
    run_random(200);
    write_camera(7'h3F, 14'd16383, 14'd0, 14'd16383, 14'd1, 16'd0);
    run_random(200);
    // A focal length of zero behaves as one.
    write_camera(7'h00, 14'd8000, 14'd8000, 14'd0, 14'd0, 16'h8000);
    run_random(150);
  endtask

  task automatic test_random_cameras();
    repeat (4) begin
      write_camera(7'($urandom), 14'($urandom), 14'($urandom), 14'($urandom_range(16383, 1)),
                   14'($urandom_range(16383, 1)), 16'($urandom));
      run_random(150);
    end
    write_camera(7'h78, 14'd5120, 14'd3840, 14'd9504, 14'd9504, 16'h4000);
    run_random(200);
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    repeat (120) begin
      send_item(dpp_pkg::OP_CONVERT, 11'($urandom_range(2047, NUM_ENTRIES)), 10'($urandom),
                10'($urandom), 16'($urandom));
    end
    run_random(100);
  endtask

  initial begin
    cam = '{x_offset: 7'h78, center_x: 14'd5120, center_y: 14'd3840,
            focal_x: 14'd9504, focal_y: 14'd9504, far_depth: 16'd0};
    foreach (entry_loaded[i]) entry_loaded[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 11;
    recv_idle_pct = 62;
    test_directed();
    run_random(100);
    test_extreme_cameras();
    send_idle_pct = 62;
    recv_idle_pct = 11;
    test_random_cameras();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    run_random(150);

    wait_idle();
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

FILE: depth_pixel_to_point.f
+incdir+rtl/core
rtl/core/dpp_pkg.sv
rtl/core/dpp_front.sv
rtl/core/dpp_fifo.sv
rtl/core/dpp_div.sv
rtl/core/dpp_back.sv
rtl/core/depth_pixel_to_point.sv
tb/sv/depth_pixel_to_point_tb.sv
